// ===== design/adcavg_pkg.sv =====
// Shared types, constants and helpers for the ADC averaging and CV/CC mode block.
package adcavg_pkg;

  // Window geometry
  localparam int WINDOW = 16;
  localparam int LOG2W = $clog2(WINDOW);
  localparam int WPOS_W = LOG2W;
  localparam int QUALIFY_COUNT = 3;
  localparam int CNT_W = $clog2(QUALIFY_COUNT + 1);

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int NUM_CH = 4;
  localparam int ROW_W = NUM_CH * SAMPLE_W;
  localparam int SUM_W = 20;
  localparam int SET_W = 14;
  localparam int IOUT_W = 13;
  localparam int VOLT_W = 16;

  // Multiplier and scaling widths
  localparam int MUL_W = 20;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SHIFT = LOG2W + 16;
  localparam int SC_W = PROD_W + 1 - SHIFT;
  localparam int CMP_W = SC_W + 7;
  localparam int K_W = 8;
  localparam int THR_W = SET_W + K_W;

  // Stream widths
  localparam int IN_W = 72;
  localparam int OUT_W = 64;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_GAIN = 3'd0,
    REG_VIN_GAIN     = 3'd1,
    REG_VOUT_GAIN    = 3'd2,
    REG_ENTER_PCT    = 3'd3,
    REG_EXIT_PCT     = 3'd4,
    REG_MIN_SET      = 3'd5,
    REG_VOUT_ZERO    = 3'd6,
    REG_IOUT_ZERO    = 3'd7
  } cfg_reg_t;

  localparam logic [17:0] RST_CURRENT_GAIN = 18'd130862;
  localparam logic [19:0] RST_VIN_GAIN = 20'd579216;
  localparam logic [19:0] RST_VOUT_GAIN = 20'd528818;
  localparam logic [6:0] RST_ENTER_PCT = 7'd5;
  localparam logic [6:0] RST_EXIT_PCT = 7'd5;
  localparam logic [13:0] RST_MIN_SET = 14'd100;
  localparam logic [9:0] RST_VOUT_ZERO = 10'd150;
  localparam logic [6:0] RST_IOUT_ZERO = 7'd3;

  localparam logic [K_W-1:0] PCT_FULL = 8'd100;
  localparam logic [SC_W-1:0] IOUT_MAX = SC_W'(8191);
  localparam logic [SC_W-1:0] VOLT_MAX = SC_W'(65535);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL_I,
    ST_MUL_V,
    ST_MUL_O,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MSEL_THR,
    MSEL_IOUT,
    MSEL_VIN,
    MSEL_VOUT
  } mul_sel_t;

  typedef struct packed {
    logic load_in;   // capture input, read window row
    logic upd_sum;   // update sums, write window row
    logic mul_en;    // load product register
    mul_sel_t mul_sel;
    logic ld_thr;    // park threshold product
    logic ld_iout;   // scale current product
    logic ld_vin;    // scale input voltage product
    logic fin;       // finish: load result, update mode counters
  } dp_cmd_t;

  // Round half up and divide by WINDOW * 65536
  function automatic logic [SC_W-1:0] scale_prod(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    t = {1'b0, p} + ((PROD_W + 1)'(1) << (SHIFT - 1));
    return t[PROD_W:SHIFT];
  endfunction

endpackage

// ===== design/adcavg_ctrl.sv =====
// Sequencer for the ADC averaging block: steps the shared multiplier and output handoff.
module adcavg_ctrl
  import adcavg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  output logic    m_axis_tvalid,
  input  logic    m_axis_tready,
  output dp_cmd_t cmd
);

  state_t state, state_next;
  logic out_valid;
  logic out_free;

  assign out_free = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = MSEL_THR;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.upd_sum = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MSEL_THR;
        state_next = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.ld_thr = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MSEL_IOUT;
        state_next = ST_MUL_V;
      end
      ST_MUL_V: begin
        cmd.ld_iout = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MSEL_VIN;
        state_next = ST_MUL_O;
      end
      ST_MUL_O: begin
        cmd.ld_vin = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MSEL_VOUT;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.fin = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/adcavg_dp.sv =====
// Datapath: window memory, running sums, shared multiplier, scaling and mode counters.
module adcavg_dp
  import adcavg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [17:0] current_gain;
  logic [19:0] vin_gain;
  logic [19:0] vout_gain;
  logic [6:0] enter_pct;
  logic [6:0] exit_pct;
  logic [SET_W-1:0] min_set;
  logic [9:0] vout_zero;
  logic [6:0] iout_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_gain <= RST_CURRENT_GAIN;
      vin_gain <= RST_VIN_GAIN;
      vout_gain <= RST_VOUT_GAIN;
      enter_pct <= RST_ENTER_PCT;
      exit_pct <= RST_EXIT_PCT;
      min_set <= RST_MIN_SET;
      vout_zero <= RST_VOUT_ZERO;
      iout_zero <= RST_IOUT_ZERO;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CURRENT_GAIN: current_gain <= cfg_data[17:0];
        REG_VIN_GAIN:     vin_gain <= cfg_data[19:0];
        REG_VOUT_GAIN:    vout_gain <= cfg_data[19:0];
        REG_ENTER_PCT:    enter_pct <= cfg_data[6:0];
        REG_EXIT_PCT:     exit_pct <= cfg_data[6:0];
        REG_MIN_SET:      min_set <= cfg_data[SET_W-1:0];
        REG_VOUT_ZERO:    vout_zero <= cfg_data[9:0];
        REG_IOUT_ZERO:    iout_zero <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Input capture
  logic [ROW_W-1:0] in_row;
  logic in_on;
  logic in_menu;
  logic [SET_W-1:0] in_set;
  logic in_mode;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_row <= s_axis_tdata[ROW_W-1:0];
      in_on <= s_axis_tdata[48];
      in_menu <= s_axis_tdata[49];
      in_set <= s_axis_tdata[63:50];
      in_mode <= s_axis_tdata[64];
    end
  end

  // Window memory: one row holds one sample of every channel
  logic [ROW_W-1:0] win_mem [WINDOW];
  logic [WINDOW-1:0] win_vld;
  logic [WPOS_W-1:0] wpos;
  logic [ROW_W-1:0] rd_row;
  logic rd_vld;
  logic [ROW_W-1:0] old_row;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rd_row <= win_mem[wpos];
    end
    if (cmd.upd_sum) begin
      win_mem[wpos] <= in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
      wpos <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        rd_vld <= win_vld[wpos];
      end
      if (cmd.upd_sum) begin
        win_vld[wpos] <= 1'b1;
        wpos <= wpos + WPOS_W'(1);
      end
    end
  end

  // Entries never written read as zero samples
  assign old_row = rd_vld ? rd_row : '0;

  // Running sums
  logic [SUM_W-1:0] sums [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c] <= '0;
      end
    end else if (cmd.upd_sum) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c] <= sums[c] - SUM_W'(old_row[c*SAMPLE_W +: SAMPLE_W])
                   + SUM_W'(in_row[c*SAMPLE_W +: SAMPLE_W]);
      end
    end
  end

  // Shared multiplier
  logic [K_W-1:0] k_enter;
  logic [K_W-1:0] k_exit;
  logic exit_neg;
  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;

  assign exit_neg = (exit_pct > PCT_FULL[6:0]) || PCT_FULL[7];
  assign k_enter = PCT_FULL + {1'b0, enter_pct};
  assign k_exit = exit_neg ? '0 : (PCT_FULL - {1'b0, exit_pct});

  always_comb begin
    case (cmd.mul_sel)
      MSEL_THR: begin
        mul_a = MUL_W'(in_set);
        mul_b = MUL_W'(in_mode ? k_exit : k_enter);
      end
      MSEL_IOUT: begin
        mul_a = sums[1];
        mul_b = MUL_W'(current_gain);
      end
      MSEL_VIN: begin
        mul_a = sums[2];
        mul_b = vin_gain;
      end
      MSEL_VOUT: begin
        mul_a = sums[3];
        mul_b = vout_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Scaling
  logic [SC_W-1:0] prod_sc;
  logic [THR_W-1:0] thr;
  logic [SC_W-1:0] iout;
  logic [SC_W-1:0] vin;

  assign prod_sc = scale_prod(prod);

  always_ff @(posedge clk) begin
    if (cmd.ld_thr) begin
      thr <= prod[THR_W-1:0];
    end
    if (cmd.ld_iout) begin
      iout <= (prod_sc < SC_W'(iout_zero)) ? '0 : prod_sc;
    end
    if (cmd.ld_vin) begin
      vin <= prod_sc;
    end
  end

  // Mode decision
  logic [SC_W-1:0] vout;
  logic [CMP_W-1:0] io100;
  logic [CMP_W-1:0] thr_x;
  logic active;
  logic at_min;
  logic exit_hit;
  logic enter_hit;
  logic [CNT_W-1:0] enter_cnt, enter_cnt_next;
  logic [CNT_W-1:0] exit_cnt, exit_cnt_next;
  logic [CNT_W-1:0] enter_inc;
  logic [CNT_W-1:0] exit_inc;
  logic mode_next;

  assign vout = (prod_sc < SC_W'(vout_zero)) ? '0 : prod_sc;
  assign io100 = (CMP_W'(iout) << 6) + (CMP_W'(iout) << 5) + (CMP_W'(iout) << 2);
  assign thr_x = CMP_W'(thr);
  assign active = in_on && in_menu;
  assign at_min = (in_set == min_set);
  assign exit_hit = !exit_neg && (io100 <= thr_x);
  assign enter_hit = (io100 >= thr_x);
  assign enter_inc = enter_cnt + CNT_W'(1);
  assign exit_inc = exit_cnt + CNT_W'(1);

  always_comb begin
    mode_next = in_mode;
    enter_cnt_next = '0;
    exit_cnt_next = '0;
    if (!active) begin
      mode_next = in_mode;
    end else if (at_min) begin
      mode_next = 1'b0;
    end else if (in_mode) begin
      if (exit_hit) begin
        if (exit_inc >= CNT_W'(QUALIFY_COUNT)) begin
          mode_next = 1'b0;
        end else begin
          exit_cnt_next = exit_inc;
        end
      end
    end else begin
      if (enter_hit) begin
        if (enter_inc >= CNT_W'(QUALIFY_COUNT)) begin
          mode_next = 1'b1;
        end else begin
          enter_cnt_next = enter_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_cnt <= '0;
      exit_cnt <= '0;
    end else if (cmd.fin) begin
      enter_cnt <= enter_cnt_next;
      exit_cnt <= exit_cnt_next;
    end
  end

  // Result register
  logic [SAMPLE_W-1:0] ntc_avg;
  logic [IOUT_W-1:0] iout_ma;
  logic [VOLT_W-1:0] vin_mv;
  logic [VOLT_W-1:0] vout_mv;

  assign ntc_avg = sums[0][LOG2W +: SAMPLE_W];
  assign iout_ma = (iout > IOUT_MAX) ? IOUT_MAX[IOUT_W-1:0] : iout[IOUT_W-1:0];
  assign vin_mv = (vin > VOLT_MAX) ? VOLT_MAX[VOLT_W-1:0] : vin[VOLT_W-1:0];
  assign vout_mv = (vout > VOLT_MAX) ? VOLT_MAX[VOLT_W-1:0] : vout[VOLT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      m_axis_tdata <= {6'd0, mode_next, vout_mv, vin_mv, iout_ma, ntc_avg};
    end
  end

endmodule

// ===== design/adc_average_cv_cc_mode_switch.sv =====
// Top level of the ADC moving-average front end with CV/CC mode switching.
// Behind a registered row read, an item walks the sum, multiply and finish states; finish
// waits while the output stalls, and a new item is taken only after it. The steps use the
// single shared 20x20 multiplier in turn (threshold, then current, input and output voltage).
// Reset (rst, synchronous, active high) clears window valid bits, sums, write position,
// mode counters and output valid, and loads the register defaults.
module adc_average_cv_cc_mode_switch
  import adcavg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // tdata, lowest bit up: ntc_raw[11:0], iout_raw[23:12], vin_raw[35:24], vout_raw[47:36],
  // output_on[48], menu_is_output[49], set_current_ma[63:50], mode_now[64], zero fill
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,
  // tdata, lowest bit up: ntc_avg[11:0], iout_ma[24:12], vin_mv[40:25], vout_mv[56:41],
  // mode_next[57], zero fill
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,
  // configuration writes; the user must write only while no item is in flight, the block does not enforce it
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Commands from the sequencer; the datapath needs no status back, since every
  // step has a fixed length and only the output handoff can stall.
  dp_cmd_t cmd;

  // Sequencer: takes one transfer in idle, walks the multiplier steps, and
  // waits in the final step until the output register is empty or drained.
  adcavg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  // Datapath: window row memory, four running sums, shared multiplier,
  // rounding, zero thresholds, saturation and the hysteresis counters.
  adcavg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

// ===== design/adcavg_chk.sv =====
// Port-level checker for the ADC averaging block, bound to the top level.
module adcavg_chk
  import adcavg_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_W-1:0]       s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_W-1:0]      m_axis_tdata,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // No result survives reset.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // One item at a time: no second transfer right after an accepted one.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // A new result appears only at the end of an item's work.
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without an item in flight");

  // Stream padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:58] == '0))
    else $error("result padding not zero");

endmodule

bind adc_average_cv_cc_mode_switch adcavg_chk u_chk (.*);

// ===== verif/adc_average_cv_cc_mode_switch_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ADC moving-average front end and its CV/CC mode switch.
module adc_average_cv_cc_mode_switch_tb;
  import adcavg_pkg::*;

  localparam logic MODE_CV = 1'b0;
  localparam logic MODE_CC = 1'b1;
  localparam int SCALE_SH = $clog2(WINDOW) + 16;
  localparam int N_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 58;
  localparam int PH_MAX = 0;
  localparam int PH_ZERO = 1;
  localparam int PH_HOLD = 2;
  localparam int PH_PAUSE = 3;
  localparam int PH_CALM = 5;
  localparam int PH_DEFAULT = N_PHASES - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;

  // One input item; the last field listed sits in the lowest bits.
  typedef struct packed {
    logic        mode_now;
    logic [13:0] set_current_ma;
    logic        menu_is_output;
    logic        output_on;
    logic [11:0] vout_raw, vin_raw, iout_raw, ntc_raw;
  } adc_item_t;

  // One result item, same packing.
  typedef struct packed {
    logic        mode_next;
    logic [15:0] vout_mv;
    logic [15:0] vin_mv;
    logic [12:0] iout_ma;
    logic [11:0] ntc_avg;
  } reading_t;

  typedef struct {
    adc_item_t item;
    bit        typed;
    reading_t  want;
  } dir_row_t;

  localparam reading_t QUIET_CV = '0;
  localparam reading_t QUIET_CC = '{mode_next: MODE_CC, default: '0};

  logic                  clk;
  logic                  rst;
  logic                  s_valid;
  logic [IN_W-1:0]       s_data;
  logic                  m_ready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_W-1:0]      m_axis_tdata;

  adc_average_cv_cc_mode_switch dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: sample windows, running sums, mode qualification counters,
  // and a shadow copy of the register file.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] win_mem [NUM_CH][WINDOW];
  logic [SUM_W-1:0]    win_sum [NUM_CH];
  int                  wr_slot;
  int                  enter_run;
  int                  exit_run;
  logic                mode_seen;

  logic [17:0] r_gain_i;
  logic [19:0] r_gain_vin;
  logic [19:0] r_gain_vout;
  logic [6:0]  r_enter_pct;
  logic [6:0]  r_exit_pct;
  logic [13:0] r_min_set;
  logic [9:0]  r_vout_zero;
  logic [6:0]  r_iout_zero;

  reading_t  pending_readings [$];
  dir_row_t  dir_rows [$];
  int        err_cnt;
  bit        tx_idle_on;
  bit        rx_idle_on;
  bit        long_hold;
  int        lvl [NUM_CH];

  function automatic void clear_meter();
    for (int c = 0; c < NUM_CH; c++) begin
      win_sum[c] = '0;
      for (int k = 0; k < WINDOW; k++) win_mem[c][k] = '0;
    end
    wr_slot = 0;
    enter_run = 0;
    exit_run = 0;
    mode_seen = MODE_CV;
    r_gain_i = 18'd130862;
    r_gain_vin = 20'd579216;
    r_gain_vout = 20'd528818;
    r_enter_pct = 7'd5;
    r_exit_pct = 7'd5;
    r_min_set = 14'd100;
    r_vout_zero = 10'd150;
    r_iout_zero = 7'd3;
  endfunction

  // Window sum times a Q16 gain, divided by WINDOW*65536, half rounded up.
  function automatic longint to_units(logic [SUM_W-1:0] s, logic [19:0] gain);
    longint p;
    p = longint'(s) * longint'(gain);
    return (p + (longint'(1) << (SCALE_SH - 1))) >>> SCALE_SH;
  endfunction

  // Current in mA after zeroing, before saturation (what the mode logic compares).
  function automatic longint current_of(logic [SUM_W-1:0] s);
    longint ma;
    ma = to_units(s, 20'(r_gain_i));
    if (ma < longint'(r_iout_zero)) ma = 0;
    return ma;
  endfunction

  // Current the next item would produce, without touching the window.
  function automatic longint peek_current(logic [SAMPLE_W-1:0] s);
    logic [SUM_W-1:0] nxt;
    nxt = win_sum[1] - win_mem[1][wr_slot] + s;
    return current_of(nxt);
  endfunction

  // Push one item through the averaging windows and the mode switch.
  function automatic reading_t advance_meter(adc_item_t it);
    logic [SAMPLE_W-1:0] smp [NUM_CH];
    longint ma;
    longint vi;
    longint vo;
    longint io100;
    longint thr;
    logic mode;
    reading_t r;
    smp[0] = it.ntc_raw;
    smp[1] = it.iout_raw;
    smp[2] = it.vin_raw;
    smp[3] = it.vout_raw;
    for (int c = 0; c < NUM_CH; c++) begin
      win_sum[c] = win_sum[c] - win_mem[c][wr_slot] + smp[c];
      win_mem[c][wr_slot] = smp[c];
    end
    wr_slot = (wr_slot + 1) % WINDOW;
    ma = current_of(win_sum[1]);
    vi = to_units(win_sum[2], r_gain_vin);
    vo = to_units(win_sum[3], r_gain_vout);
    if (vo < longint'(r_vout_zero)) vo = 0;
    mode = it.mode_now;
    if (!(it.output_on && it.menu_is_output)) begin
      // not regulating from this screen: hold the mode, drop any qualification
      enter_run = 0;
      exit_run = 0;
    end else if (it.set_current_ma == r_min_set) begin
      mode = MODE_CV;
      enter_run = 0;
      exit_run = 0;
    end else begin
      io100 = ma * 100;
      if (mode == MODE_CC) begin
        // exit percent above 100 gives a negative threshold that never qualifies
        thr = longint'(it.set_current_ma) * (100 - longint'(r_exit_pct));
        if (io100 <= thr) begin
          exit_run++;
          if (exit_run >= QUALIFY_COUNT) begin
            mode = MODE_CV;
            exit_run = 0;
          end
        end else begin
          exit_run = 0;
        end
        enter_run = 0;
      end else begin
        thr = longint'(it.set_current_ma) * (100 + longint'(r_enter_pct));
        if (io100 >= thr) begin
          enter_run++;
          if (enter_run >= QUALIFY_COUNT) begin
            mode = MODE_CC;
            enter_run = 0;
          end
        end else begin
          enter_run = 0;
        end
        exit_run = 0;
      end
    end
    r.ntc_avg = SAMPLE_W'(win_sum[0] / WINDOW);
    r.iout_ma = (ma > 8191) ? 13'h1FFF : ma[12:0];
    r.vin_mv = (vi > 65535) ? 16'hFFFF : vi[15:0];
    r.vout_mv = (vo > 65535) ? 16'hFFFF : vo[15:0];
    r.mode_next = mode;
    mode_seen = mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic adc_item_t item_of(logic [11:0] n, logic [11:0] i, logic [11:0] v,
                                        logic [11:0] o, logic on, logic menu,
                                        logic [13:0] set, logic mode);
    adc_item_t it;
    it.ntc_raw = n;
    it.iout_raw = i;
    it.vin_raw = v;
    it.vout_raw = o;
    it.output_on = on;
    it.menu_is_output = menu;
    it.set_current_ma = set;
    it.mode_now = mode;
    return it;
  endfunction

  task automatic add_row(adc_item_t it, bit typed, reading_t want);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  function automatic int pick_level();
    int v;
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 4095;
      default: v = int'($urandom_range(0, 4095));
    endcase
    return v;
  endfunction

  function automatic logic [11:0] near_level(int base);
    int v;
    v = base + int'($urandom_range(0, 64)) - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Fully random item: every bit of every field free.
  function automatic adc_item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(adc_item_t)-1:0];
  endfunction

  // Regulating item that follows the predicted mode, with the set current placed
  // around the switching threshold. lean 0 pushes beyond it, 1 sits on it, 2 stays clear.
  function automatic adc_item_t track_item(int lean);
    adc_item_t it;
    longint io100;
    longint d;
    longint base;
    longint pick;
    it.ntc_raw = near_level(lvl[0]);
    it.iout_raw = near_level(lvl[1]);
    it.vin_raw = near_level(lvl[2]);
    it.vout_raw = near_level(lvl[3]);
    it.output_on = ($urandom_range(0, 15) != 0);
    it.menu_is_output = ($urandom_range(0, 15) != 0);
    it.mode_now = mode_seen;
    io100 = peek_current(it.iout_raw) * 100;
    if (mode_seen == MODE_CV) begin
      d = 100 + longint'(r_enter_pct);
      base = io100 / d;
      case (lean)
        0: pick = base - longint'($urandom_range(0, 3));
        1: pick = base + longint'($urandom_range(0, 2)) - 1;
        default: pick = base + longint'($urandom_range(1, 200));
      endcase
    end else begin
      d = 100 - longint'(r_exit_pct);
      if (d <= 0) begin
        pick = longint'($urandom_range(0, 16383));
      end else begin
        base = (io100 + d - 1) / d;
        case (lean)
          0: pick = base + longint'($urandom_range(0, 3));
          1: pick = base + longint'($urandom_range(0, 2)) - 1;
          default: pick = base - longint'($urandom_range(1, 200));
        endcase
      end
    end
    if ($urandom_range(0, 11) == 0) pick = longint'(r_min_set);
    if (pick < 0) pick = 0;
    if (pick > 16383) pick = 16383;
    it.set_current_ma = pick[13:0];
    return it;
  endfunction

  // Offer one item, wait for the transfer, then log its expected reading.
  task automatic send_item(adc_item_t it, bit typed, reading_t want);
    reading_t pred;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {{(IN_W - $bits(adc_item_t)){1'b0}}, it};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = advance_meter(it);
    pending_readings.push_back(typed ? want : pred);
  endtask

  // Stop offering, let every reading drain, then give the pipeline time to go quiet.
  task automatic settle();
    s_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hold the write strobe across back-to-back writes; the caller drops it.
  task automatic write_reg(cfg_reg_t r, logic [19:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    case (r)
      REG_CURRENT_GAIN: r_gain_i = d[17:0];
      REG_VIN_GAIN:     r_gain_vin = d;
      REG_VOUT_GAIN:    r_gain_vout = d;
      REG_ENTER_PCT:    r_enter_pct = d[6:0];
      REG_EXIT_PCT:     r_exit_pct = d[6:0];
      REG_MIN_SET:      r_min_set = d[13:0];
      REG_VOUT_ZERO:    r_vout_zero = d[9:0];
      REG_IOUT_ZERO:    r_iout_zero = d[6:0];
      default: ;
    endcase
  endtask

  function automatic logic [19:0] pct_choice();
    logic [19:0] v;
    case ($urandom_range(0, 3))
      0: v = 20'd0;
      1: v = 20'($urandom_range(0, 20));
      2: v = 20'($urandom_range(21, 127));
      default: v = 20'd5;
    endcase
    return v;
  endfunction

  // Load the register file for one phase. Random phases carry junk above the width
  // of each register narrower than the data port so that masking is exercised too.
  task automatic program_phase(int ph);
    logic [19:0] gi, gv, go, ep, xp, ms, vz, iz;
    case (ph)
      PH_MAX: begin
        gi = '1; gv = '1; go = '1; ep = '1; xp = '1; ms = '1; vz = '1; iz = '1;
      end
      PH_ZERO: begin
        gi = '0; gv = '0; go = '0; ep = '0; xp = '0; ms = '0; vz = '0; iz = '0;
      end
      PH_DEFAULT: begin
        gi = 20'd130862; gv = 20'd579216; go = 20'd528818; ep = 20'd5;
        xp = 20'd5; ms = 20'd100; vz = 20'd150; iz = 20'd3;
      end
      default: begin
        gi = 20'($urandom);
        gv = 20'($urandom);
        go = 20'($urandom);
        ep = pct_choice() | (20'($urandom) & 20'hFFF80);
        xp = pct_choice() | (20'($urandom) & 20'hFFF80);
        ms = ($urandom_range(0, 1) != 0) ? 20'($urandom_range(0, 400))
                                         : 20'($urandom_range(0, 16383));
        ms = ms | (20'($urandom) & 20'hFC000);
        vz = 20'($urandom_range(0, 1023)) | (20'($urandom) & 20'hFFC00);
        iz = 20'($urandom_range(0, 127)) | (20'($urandom) & 20'hFFF80);
      end
    endcase
    write_reg(REG_CURRENT_GAIN, gi);
    write_reg(REG_VIN_GAIN, gv);
    write_reg(REG_VOUT_GAIN, go);
    write_reg(REG_ENTER_PCT, ep);
    write_reg(REG_EXIT_PCT, xp);
    write_reg(REG_MIN_SET, ms);
    write_reg(REG_VOUT_ZERO, vz);
    write_reg(REG_IOUT_ZERO, iz);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls in bursts, steady stretches, and one long hold-off
  // on request so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin
    m_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each output transfer against the oldest expected reading.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    reading_t got;
    reading_t want;
    if (!rst && m_axis_tvalid && m_ready) begin
      got = m_axis_tdata[$bits(reading_t)-1:0];
      if (pending_readings.size() == 0) begin
        $error("result transfer with no expected reading: tdata %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_readings.pop_front();
        check_field("ntc_avg", 16'(want.ntc_avg), 16'(got.ntc_avg));
        check_field("iout_ma", 16'(want.iout_ma), 16'(got.iout_ma));
        check_field("vin_mv", want.vin_mv, got.vin_mv);
        check_field("vout_mv", want.vout_mv, got.vout_mv);
        check_field("mode_next", 16'(want.mode_next), 16'(got.mode_next));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table at reset settings, then all-ones, all-zero, random and default phases.
  // ---------------------------------------------------------------------------
  initial begin
    adc_item_t it;
    int cnt;
    int run_len;
    int lean;
    bit tracking;
    rst <= 1'b1;
    s_valid <= 1'b0;
    s_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_CURRENT_GAIN;
    cfg_data <= '0;
    err_cnt = 0;
    long_hold = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int c = 0; c < NUM_CH; c++) lvl[c] = 0;
    clear_meter();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // output off: mode held, window still all zero
    add_row(item_of(0, 0, 0, 0, 1'b0, 1'b0, 14'd0, MODE_CC), 1'b1, QUIET_CC);
    // settings menu shown: mode held
    add_row(item_of(0, 0, 0, 0, 1'b1, 1'b0, 14'h3FFF, MODE_CC), 1'b1, QUIET_CC);
    // set current equal to the minimum forces CV
    add_row(item_of(0, 0, 0, 0, 1'b1, 1'b1, 14'd100, MODE_CC), 1'b1, QUIET_CV);
    // zero current meets a zero enter threshold three times running
    repeat (3) add_row(item_of(0, 0, 0, 0, 1'b1, 1'b1, 14'd0, MODE_CV), 1'b0, QUIET_CV);
    // alternating bit patterns on every field
    add_row(item_of(12'hAAA, 12'h555, 12'hAAA, 12'h555, 1'b1, 1'b1, 14'h2AAA, MODE_CV),
            1'b0, QUIET_CV);
    add_row(item_of(12'h555, 12'hAAA, 12'h555, 12'hAAA, 1'b1, 1'b1, 14'h1555, MODE_CC),
            1'b0, QUIET_CV);
    // full scale from here on fills the window; CC at the largest set qualifies an exit
    repeat (3) add_row(item_of('1, '1, '1, '1, 1'b1, 1'b1, 14'h3FFF, MODE_CC),
                       1'b0, QUIET_CV);
    // CV with a small set qualifies an entry
    repeat (3) add_row(item_of('1, '1, '1, '1, 1'b1, 1'b1, 14'd200, MODE_CV),
                       1'b0, QUIET_CV);
    // CC exit run broken by the output turning off
    repeat (2) add_row(item_of('1, '1, '1, '1, 1'b1, 1'b1, 14'd10000, MODE_CC),
                       1'b0, QUIET_CV);
    add_row(item_of('1, '1, '1, '1, 1'b0, 1'b1, 14'd10000, MODE_CC), 1'b0, QUIET_CV);
    add_row(item_of('1, '1, '1, '1, 1'b1, 1'b1, 14'd10000, MODE_CC), 1'b0, QUIET_CV);
    // window full of full scale: largest averages at reset gains
    repeat (6) add_row(item_of('1, '1, '1, '1, 1'b1, 1'b1, 14'd200, MODE_CC),
                       1'b0, QUIET_CV);
    foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      tx_idle_on = (ph != PH_CALM) && (ph != PH_DEFAULT);
      rx_idle_on = tx_idle_on;
      program_phase(ph);
      // back up the output while the sender keeps offering
      if (ph == PH_HOLD) long_hold = 1'b1;
      cnt = 0;
      while (cnt < ITEMS_PER_PHASE) begin
        run_len = $urandom_range(3, 8);
        tracking = ($urandom_range(0, 9) < 7);
        lean = $urandom_range(0, 2);
        if ($urandom_range(0, 1) != 0) begin
          for (int c = 0; c < NUM_CH; c++) lvl[c] = pick_level();
        end
        for (int k = 0; k < run_len && cnt < ITEMS_PER_PHASE; k++) begin
          // let the block run completely dry once in mid-phase
          if (ph == PH_PAUSE && cnt == ITEMS_PER_PHASE / 2) settle();
          it = tracking ? track_item(lean) : noise_item();
          send_item(it, 1'b0, QUIET_CV);
          cnt++;
        end
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("adc_average_cv_cc_mode_switch_tb passed");
    end else begin
      $display("adc_average_cv_cc_mode_switch_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("adc_average_cv_cc_mode_switch_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/adcavg_pkg.sv
design/adcavg_ctrl.sv
design/adcavg_dp.sv
design/adc_average_cv_cc_mode_switch.sv
design/adcavg_chk.sv
verif/adc_average_cv_cc_mode_switch_tb.sv
